[design/tae_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tae_pkg;

    // Field and register widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int DELAY_W  = 17;
    localparam int Q_FRAC   = 15;

    // Default history depth in samples
    localparam int HISTORY_DEPTH_DEF = 131072;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_GAIN  = 2'd3;

    // Requests held inside the pipeline at most: tap stage, scale stage, output register
    localparam int PIPE_SLOTS = 3;

endpackage

`default_nettype wire

[design/tae_history_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tae_history_ram #(
    parameter int DEPTH = tae_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  wire logic [tae_pkg::SAMPLE_W-1:0]  i_wdata,
    input  wire logic                          i_re,
    input  wire logic [$clog2(DEPTH)-1:0]      i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0]      i_raddr_b,
    output logic      [tae_pkg::SAMPLE_W-1:0]  o_rdata_a,
    output logic      [tae_pkg::SAMPLE_W-1:0]  o_rdata_b
);

    logic [tae_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic [tae_pkg::SAMPLE_W-1:0] r_rdata_a;
    logic [tae_pkg::SAMPLE_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data while no new read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

[design/two_tap_audio_echo_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Two-tap feedforward echo on an unsigned 16-bit audio stream.
// Input channel: i_in_valid / o_in_stall carry one request of i_sample_in and
// i_buffer_start; it is taken at a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry o_sample_out, one result per
// request, in order.
// Configuration: set i_cfg_we with i_cfg_index and i_cfg_data to write a delay
// (samples) or a Q1.15 gain; write only while the block is idle.
// Throughput: one request per cycle while o_in_stall is low. The history memory
// has one write port and two read ports, so both taps are read and the new
// sample stored in the cycle the request is taken.
// Pipeline: memory read, tap scaling and output sum lie between acceptance and
// o_out_valid. A tap with a non-zero delay never reads the slot written in the
// same cycle, a zero delay takes the incoming sample itself, and earlier samples
// are already stored, so no forwarding is needed.
// Reset clears the write pointer, the sample count, the configuration registers
// and all valid flags; the history memory is not cleared, as no tap reads an entry
// before it has been written.
// When the receiver stalls, the output register holds its result; the inner
// stages keep filling, and o_in_stall rises once all three stages are full.
module two_tap_audio_echo_top #(
    parameter int HISTORY_DEPTH = tae_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [tae_pkg::SAMPLE_W-1:0]   i_sample_in,
    input  wire logic                           i_buffer_start,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [tae_pkg::SAMPLE_W-1:0]   o_sample_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [tae_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tae_pkg::DELAY_W-1:0]    i_cfg_data
);

    localparam int SW     = tae_pkg::SAMPLE_W;
    localparam int DW     = tae_pkg::DELAY_W;
    localparam int GW     = tae_pkg::GAIN_W;
    localparam int PROD_W = SW + GW;
    localparam int ADDR_W = $clog2(HISTORY_DEPTH);
    localparam int SEEN_W = $clog2(HISTORY_DEPTH + 1);
    // Wide enough for a signed difference of pointer and delay
    localparam int EXT_W  = ((ADDR_W + 1 > DW) ? ADDR_W + 1 : DW) + 1;

    localparam logic [EXT_W-1:0]  DEPTH_X  = EXT_W'(HISTORY_DEPTH);
    localparam logic [ADDR_W-1:0] WP_LAST  = ADDR_W'(HISTORY_DEPTH - 1);
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(HISTORY_DEPTH);

    // Slot that lies the given delay behind the write pointer, wrapped at the depth
    function automatic logic [ADDR_W-1:0] f_tap_addr(
        input logic [ADDR_W-1:0] wp,
        input logic [DW-1:0]     dly
    );
        logic [EXT_W-1:0] diff;
        diff = EXT_W'(wp) - EXT_W'(dly);
        if (diff[EXT_W-1]) begin
            diff = diff + DEPTH_X;
        end
        return diff[ADDR_W-1:0];
    endfunction

    // A tap counts once its delay fits the store and enough samples have passed
    function automatic logic f_tap_on(
        input logic [DW-1:0]     dly,
        input logic [SEEN_W-1:0] seen
    );
        return (EXT_W'(dly) < DEPTH_X) && (EXT_W'(seen) >= EXT_W'(dly));
    endfunction

    // Configuration registers
    logic [DW-1:0] r_first_delay;
    logic [DW-1:0] r_second_delay;
    logic [GW-1:0] r_first_gain;
    logic [GW-1:0] r_second_gain;

    // Stream state
    logic [ADDR_W-1:0] r_wp;
    logic [ADDR_W-1:0] n_wp;
    logic [SEEN_W-1:0] r_seen;
    logic [SEEN_W-1:0] n_seen;
    logic [SEEN_W-1:0] w_seen;

    // Handshake
    logic w_out_ready;
    logic w_s2_ready;
    logic w_s1_ready;
    logic w_in_acc;
    logic w_s1_move;
    logic w_s2_move;

    // Tap stage (memory read in flight)
    logic          r_v1;
    logic [SW-1:0] r_cur1;
    logic          r_on_a1;
    logic          r_on_b1;
    logic          r_zero_a1;
    logic          r_zero_b1;
    logic [ADDR_W-1:0] w_raddr_a;
    logic [ADDR_W-1:0] w_raddr_b;
    logic [SW-1:0] w_rd_a;
    logic [SW-1:0] w_rd_b;

    // Scale stage
    logic              r_v2;
    logic [SW-1:0]     r_cur2;
    logic [SW-1:0]     r_term_a2;
    logic [SW-1:0]     r_term_b2;
    logic [SW-1:0]     w_past_a;
    logic [SW-1:0]     w_past_b;
    logic [PROD_W-1:0] w_prod_a;
    logic [PROD_W-1:0] w_prod_b;
    logic [SW-1:0]     n_term_a;
    logic [SW-1:0]     n_term_b;

    // Output register
    logic          r_out_valid;
    logic [SW-1:0] r_out;
    logic [SW-1:0] n_sum;

    // Each stage advances when the one after it is empty or moving on
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_s2_ready  = !r_v2 || w_out_ready;
    assign w_s1_ready  = !r_v1 || w_s2_ready;
    assign w_in_acc    = i_in_valid && w_s1_ready;
    assign w_s1_move   = r_v1 && w_s2_ready;
    assign w_s2_move   = r_v2 && w_out_ready;

    assign o_in_stall  = !w_s1_ready;

    // A buffer start restarts the count before this sample is looked at
    assign w_seen    = i_buffer_start ? '0 : r_seen;
    assign n_seen    = (w_seen < SEEN_MAX) ? w_seen + SEEN_W'(1) : w_seen;
    assign n_wp      = (r_wp == WP_LAST) ? '0 : r_wp + ADDR_W'(1);
    assign w_raddr_a = f_tap_addr(r_wp, r_first_delay);
    assign w_raddr_b = f_tap_addr(r_wp, r_second_delay);

    tae_history_ram #(
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk     (i_clk),
        .i_we      (w_in_acc),
        .i_waddr   (r_wp),
        .i_wdata   (i_sample_in),
        .i_re      (w_in_acc),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    // A zero delay scales the current sample itself
    assign w_past_a = r_zero_a1 ? r_cur1 : w_rd_a;
    assign w_past_b = r_zero_b1 ? r_cur1 : w_rd_b;
    assign w_prod_a = PROD_W'(w_past_a) * PROD_W'(r_first_gain);
    assign w_prod_b = PROD_W'(w_past_b) * PROD_W'(r_second_gain);
    assign n_term_a = r_on_a1 ? w_prod_a[tae_pkg::Q_FRAC +: SW] : '0;
    assign n_term_b = r_on_b1 ? w_prod_b[tae_pkg::Q_FRAC +: SW] : '0;

    // Wrap modulo 65536, no saturation
    assign n_sum = r_cur2 + r_term_a2 + r_term_b2;

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_delay  <= '0;
            r_second_delay <= '0;
            r_first_gain   <= '0;
            r_second_gain  <= '0;
            r_wp           <= '0;
            r_seen         <= '0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tae_pkg::CFG_FIRST_DELAY:  r_first_delay  <= i_cfg_data;
                    tae_pkg::CFG_SECOND_DELAY: r_second_delay <= i_cfg_data;
                    tae_pkg::CFG_FIRST_GAIN:   r_first_gain   <= i_cfg_data[GW-1:0];
                    tae_pkg::CFG_SECOND_GAIN:  r_second_gain  <= i_cfg_data[GW-1:0];
                endcase
            end
            if (w_in_acc) begin
                r_wp   <= n_wp;
                r_seen <= n_seen;
            end
            if (w_s1_ready) begin
                r_v1 <= i_in_valid;
            end
            if (w_s2_ready) begin
                r_v2 <= r_v1;
            end
            if (w_out_ready) begin
                r_out_valid <= r_v2;
            end
        end
    end

    // Payload registers: load only when a request moves in
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cur1    <= i_sample_in;
            r_on_a1   <= f_tap_on(r_first_delay, w_seen);
            r_on_b1   <= f_tap_on(r_second_delay, w_seen);
            r_zero_a1 <= (r_first_delay == '0);
            r_zero_b1 <= (r_second_delay == '0);
        end
        if (w_s1_move) begin
            r_cur2    <= r_cur1;
            r_term_a2 <= n_term_a;
            r_term_b2 <= n_term_b;
        end
        if (w_s2_move) begin
            r_out <= n_sum;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

endmodule

`default_nettype wire

[design/tae_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tae_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_stall,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [tae_pkg::SAMPLE_W-1:0]  i_sample_out
);

    localparam logic [2:0] SLOTS = 3'(tae_pkg::PIPE_SLOTS);

    logic       w_in_acc;
    logic       w_out_acc;
    logic [2:0] r_inflight;
    logic [2:0] n_inflight;

    assign w_in_acc   = i_in_valid && !i_in_stall;
    assign w_out_acc  = i_out_valid && !i_out_stall;
    assign n_inflight = r_inflight + 3'(w_in_acc) - 3'(w_out_acc);

    // Track requests taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_sample_out))
        else $error("stalled result changed");

    // No result without a request in flight, and never more than the pipeline holds
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> (r_inflight != 3'd0))
        else $error("result without request");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= SLOTS)
        else $error("too many requests in flight");

    // A taken request reaches the output when the receiver does not stall
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc ##1 !i_out_stall ##1 !i_out_stall |=> i_out_valid)
        else $error("result late");

endmodule

bind two_tap_audio_echo_top tae_checker u_tae_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .i_in_stall   (o_in_stall),
    .i_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .i_sample_out (o_sample_out)
);

`default_nettype wire
